>>> rtl/mwc_pkg.sv
package mwc_pkg;

  localparam int TEXT_DEPTH = 4096;
  localparam int TXT_AW     = $clog2(TEXT_DEPTH);
  localparam int POS_W      = TXT_AW + 1;

  localparam int ALPH_SIZE  = 256;
  localparam int ALPH_AW    = $clog2(ALPH_SIZE);

  localparam int FUNC_W     = 2;
  localparam int SYM_W      = 8;
  localparam int CNT_W      = 13;
  localparam int DIST_W     = 9;
  localparam int START_W    = 12;
  localparam int LEN_W      = 13;

  localparam logic [CNT_W-1:0] REQ_MAX = 13'd8191;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_TEXT   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_SRD,
    ST_SUPD
  } state_t;

  typedef struct packed {
    logic               clr;
    logic               rd_en;
    logic [ALPH_AW-1:0] rd_addr;
    logic               wr_en;
    logic [ALPH_AW-1:0] wr_addr;
    logic [CNT_W-1:0]   wr_data;
  } cnt_cmd_t;

endpackage

>>> rtl/mwc_if.sv
interface mwc_in_if;
  logic                       valid;
  logic                       ready;
  logic [mwc_pkg::FUNC_W-1:0] func;
  logic [mwc_pkg::SYM_W-1:0]  symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface mwc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mwc_pkg::START_W-1:0] window_start;
  logic [mwc_pkg::LEN_W-1:0]   window_length;
  logic                        overflow;

  modport source (output valid, output found, output window_start, output window_length,
                  output overflow, input ready);
  modport sink   (input valid, input found, input window_start, input window_length,
                  input overflow, output ready);
endinterface

>>> rtl/mwc_ram.sv
module mwc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mwc_cnt_mem.sv
module mwc_cnt_mem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mwc_pkg::cnt_cmd_t         cmd,
  output logic [mwc_pkg::CNT_W-1:0] rd_data
);
  import mwc_pkg::*;

  logic [ALPH_SIZE-1:0] vld_r;
  logic                 vld_q_r;
  logic [CNT_W-1:0]     ram_q;

  mwc_ram #(
    .DEPTH (ALPH_SIZE),
    .WIDTH (CNT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (cmd.wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (ram_q)
  );

  // an entry never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[cmd.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
    end else if (cmd.rd_en) begin
      vld_q_r <= vld_r[cmd.rd_addr];
    end
  end

  assign rd_data = vld_q_r ? ram_q : '0;

endmodule

>>> rtl/min_window_cover_finder_unit.sv
// Shortest covering window finder. Send func 1 transactions to build the target
// multiset, func 2 transactions to stream text, func 0 to clear everything; every
// transaction returns one result with the shortest window seen so far. The
// required and window count tables sit in two 256-entry synchronous RAMs with
// per-entry valid bits, so reset and clear take effect at once, with no sweep;
// the text sits in a 4096-entry RAM. An item holds the block through count read,
// update and check, and its result is registered after the check, with one more
// round of text read, count read and count write-back for every step the left
// edge moves. Left-edge steps never exceed the text bytes fed since the last
// clear. A result held in the output register by a stalled sink stalls the next
// check's hand-off. A new transaction is accepted as soon as the previous one
// has been handed to the output register.
module min_window_cover_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  mwc_in_if.sink      in_chan,
  mwc_out_if.source   out_chan
);
  import mwc_pkg::*;

  state_t              state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [SYM_W-1:0]    sym_r;
  logic                ovf_r, ovf_nxt;
  logic [DIST_W-1:0]   needed_r, needed_nxt;
  logic [DIST_W-1:0]   met_r, met_nxt;
  logic [POS_W-1:0]    left_r, left_nxt;
  logic [POS_W-1:0]    right_r, right_nxt;
  logic [START_W-1:0]  best_start_r, best_start_nxt;
  logic [LEN_W-1:0]    best_len_r, best_len_nxt;

  logic                out_valid_r;
  logic                out_found_r;
  logic [START_W-1:0]  out_start_r;
  logic [LEN_W-1:0]    out_len_r;
  logic                out_ovf_r;

  cnt_cmd_t            req_cmd, win_cmd;
  logic [CNT_W-1:0]    req_rd, win_rd;

  logic                txt_wr_en, txt_rd_en;
  logic [TXT_AW-1:0]   txt_wr_addr, txt_rd_addr;
  logic [SYM_W-1:0]    txt_rd;

  logic                accept, out_free, shrink_go, load_out, sym_oob;
  logic [CNT_W:0]      req_inc, win_inc, win_dec_inc;
  logic [CNT_W-1:0]    win_dec;
  logic [POS_W-1:0]    span;
  logic                was_met, now_met;

  mwc_cnt_mem u_req_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (req_cmd),
    .rd_data (req_rd)
  );

  mwc_cnt_mem u_win_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (win_cmd),
    .rd_data (win_rd)
  );

  mwc_ram #(
    .DEPTH (TEXT_DEPTH),
    .WIDTH (SYM_W)
  ) u_txt_mem (
    .clk     (clk),
    .wr_en   (txt_wr_en),
    .wr_addr (txt_wr_addr),
    .wr_data (sym_r),
    .rd_en   (txt_rd_en),
    .rd_addr (txt_rd_addr),
    .rd_data (txt_rd)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign shrink_go     = (needed_r != '0) && (met_r == needed_r) && (left_r < right_r);
  assign load_out      = (state_r == ST_CHECK) && !shrink_go && out_free;

  assign sym_oob     = {1'b0, sym_r} >= (SYM_W + 1)'(ALPH_SIZE);
  assign req_inc     = {1'b0, req_rd} + 1'b1;
  assign win_inc     = {1'b0, win_rd} + 1'b1;
  assign win_dec     = (win_rd != '0) ? win_rd - 1'b1 : '0;
  assign win_dec_inc = {1'b0, win_dec} + 1'b1;
  assign span        = right_r - left_r;
  assign was_met     = (req_rd != '0) && (win_rd >= req_rd);
  assign now_met     = {1'b0, win_rd} >= req_inc;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (shrink_go) begin
          state_nxt = ST_SRD;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SRD:   state_nxt = ST_SUPD;
      ST_SUPD:  state_nxt = ST_CHECK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ovf_nxt        = ovf_r;
    needed_nxt     = needed_r;
    met_nxt        = met_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    req_cmd        = '0;
    win_cmd        = '0;
    txt_wr_en      = 1'b0;
    txt_wr_addr    = right_r[TXT_AW-1:0];
    txt_rd_en      = 1'b0;
    txt_rd_addr    = left_r[TXT_AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        req_cmd.rd_en   = accept;
        req_cmd.rd_addr = in_chan.symbol[ALPH_AW-1:0];
        win_cmd.rd_en   = accept;
        win_cmd.rd_addr = in_chan.symbol[ALPH_AW-1:0];
      end
      ST_EXEC: begin
        ovf_nxt         = 1'b0;
        req_cmd.wr_addr = sym_r[ALPH_AW-1:0];
        req_cmd.wr_data = req_inc[CNT_W-1:0];
        win_cmd.wr_addr = sym_r[ALPH_AW-1:0];
        win_cmd.wr_data = win_inc[CNT_W-1:0];
        unique case (func_r)
          FUNC_CLEAR: begin
            req_cmd.clr    = 1'b1;
            win_cmd.clr    = 1'b1;
            needed_nxt     = '0;
            met_nxt        = '0;
            left_nxt       = '0;
            right_nxt      = '0;
            best_start_nxt = '0;
            best_len_nxt   = '0;
          end
          FUNC_TARGET: begin
            if (sym_oob || req_rd >= REQ_MAX) begin
              ovf_nxt = 1'b1;
            end else begin
              req_cmd.wr_en = 1'b1;
              if (req_rd == '0) begin
                needed_nxt = needed_r + 1'b1;
              end
              if (was_met && !now_met) begin
                met_nxt = met_r - 1'b1;
              end else if (!was_met && now_met) begin
                met_nxt = met_r + 1'b1;
              end
            end
          end
          FUNC_TEXT: begin
            if (sym_oob || right_r >= POS_W'(TEXT_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              txt_wr_en     = 1'b1;
              win_cmd.wr_en = 1'b1;
              right_nxt     = right_r + 1'b1;
              if (req_rd != '0 && win_inc == {1'b0, req_rd}) begin
                met_nxt = met_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      ST_CHECK: begin
        if (shrink_go) begin
          txt_rd_en = 1'b1;
          if (best_len_r == '0 || span < best_len_r) begin
            best_start_nxt = left_r[START_W-1:0];
            best_len_nxt   = span;
          end
        end
      end
      ST_SRD: begin
        req_cmd.rd_en   = 1'b1;
        req_cmd.rd_addr = txt_rd[ALPH_AW-1:0];
        win_cmd.rd_en   = 1'b1;
        win_cmd.rd_addr = txt_rd[ALPH_AW-1:0];
      end
      ST_SUPD: begin
        win_cmd.wr_en   = (win_rd != '0);
        win_cmd.wr_addr = txt_rd[ALPH_AW-1:0];
        win_cmd.wr_data = win_dec;
        if (req_rd != '0 && win_dec_inc == {1'b0, req_rd}) begin
          met_nxt = met_r - 1'b1;
        end
        left_nxt = left_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ovf_r        <= 1'b0;
      needed_r     <= '0;
      met_r        <= '0;
      left_r       <= '0;
      right_r      <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      ovf_r        <= ovf_nxt;
      needed_r     <= needed_nxt;
      met_r        <= met_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_chan.func;
      sym_r  <= in_chan.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= (best_len_r != '0);
      out_start_r <= best_start_r;
      out_len_r   <= best_len_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.window_start  = out_start_r;
  assign out_chan.window_length = out_len_r;
  assign out_chan.overflow      = out_ovf_r;

endmodule

>>> bench/min_window_cover_finder_unit_test.sv
`timescale 1ns / 1ps

module min_window_cover_finder_unit_test;
  import mwc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int MISMATCH_SHOWN = 10;
  localparam int DRAIN_CYCLES   = 50;
  localparam int LONG_SPAN      = 48;
  localparam int LATE_SPAN      = 32;
  localparam int RANDOM_ITEMS   = 150;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] window_start;
    logic [LEN_W-1:0]   window_length;
    logic               overflow;
  } cover_result_t;

  logic clk;
  logic rst_n;

  mwc_in_if  in_chan ();
  mwc_out_if out_chan ();

  min_window_cover_finder_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  int              req_tbl [ALPH_SIZE];
  int              win_tbl [ALPH_SIZE];
  logic [SYM_W-1:0] text_mem [TEXT_DEPTH];
  int              n_distinct;
  int              n_met;
  int              lo_pos;
  int              hi_pos;
  int              best_pos;
  int              best_len;

  cover_result_t   expected_covers [$];
  int              tx_idle_pct = 14;
  int              rx_idle_pct = 54;
  int              mismatches  = 0;

  function automatic void clear_cover_state();
    foreach (req_tbl[i]) begin
      req_tbl[i] = 0;
      win_tbl[i] = 0;
    end
    n_distinct = 0;
    n_met      = 0;
    lo_pos     = 0;
    hi_pos     = 0;
    best_pos   = 0;
    best_len   = 0;
  endfunction

  // Move the left edge while the window covers the target, keeping the shortest span.
  function automatic void shrink_window();
    int span;
    int c;
    while (n_distinct != 0 && n_met == n_distinct && lo_pos < hi_pos) begin
      span = hi_pos - lo_pos;
      if (best_len == 0 || span < best_len) begin
        best_pos = lo_pos;
        best_len = span;
      end
      c = text_mem[lo_pos];
      if (win_tbl[c] != 0) win_tbl[c]--;
      if (req_tbl[c] != 0 && win_tbl[c] + 1 == req_tbl[c]) n_met--;
      lo_pos++;
    end
  endfunction

  function automatic cover_result_t cover_step(input logic [FUNC_W-1:0] f,
                                               input logic [SYM_W-1:0] s);
    cover_result_t r;
    logic          ovf;
    int            req;
    int            win;
    bit            was_met;
    ovf = 1'b0;
    case (f)
      FUNC_CLEAR: begin
        clear_cover_state();
      end
      FUNC_TARGET: begin
        if (int'(s) >= ALPH_SIZE || req_tbl[s] >= int'(REQ_MAX)) begin
          ovf = 1'b1;
        end else begin
          req     = req_tbl[s];
          win     = win_tbl[s];
          was_met = (req != 0) && (win >= req);
          if (req == 0) n_distinct++;
          req_tbl[s] = req + 1;
          if (was_met && win < req + 1) n_met--;
          else if (!was_met && win >= req + 1) n_met++;
          shrink_window();
        end
      end
      FUNC_TEXT: begin
        if (int'(s) >= ALPH_SIZE || hi_pos >= TEXT_DEPTH) begin
          ovf = 1'b1;
        end else begin
          text_mem[hi_pos] = s;
          hi_pos++;
          win_tbl[s]++;
          if (req_tbl[s] != 0 && win_tbl[s] == req_tbl[s]) n_met++;
          shrink_window();
        end
      end
      default: ;
    endcase
    r.found         = (best_len != 0);
    r.window_start  = best_pos[START_W-1:0];
    r.window_length = best_len[LEN_W-1:0];
    r.overflow      = ovf;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cover_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_covers.size() == 0) begin
        if (mismatches < MISMATCH_SHOWN)
          $display("unexpected result transaction at %0t", $realtime);
        mismatches++;
      end else begin
        want = expected_covers.pop_front();
        if (out_chan.found !== want.found || out_chan.window_start !== want.window_start ||
            out_chan.window_length !== want.window_length ||
            out_chan.overflow !== want.overflow) begin
          if (mismatches < MISMATCH_SHOWN)
            $display("mismatch at %0t: exp found=%0b start=%0d len=%0d ovf=%0b, got %0b %0d %0d %0b",
                     $realtime, want.found, want.window_start, want.window_length,
                     want.overflow, out_chan.found, out_chan.window_start,
                     out_chan.window_length, out_chan.overflow);
          mismatches++;
        end
      end
    end
  end

  // Starts and ends at a falling edge; valid stays high between back-to-back transactions.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.func   <= f;
    in_chan.symbol <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_covers.push_back(cover_step(f, s));
    @(negedge clk);
  endtask

  task automatic test_basics();
    send_item(FUNC_CLEAR, 8'hFF);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_UNUSED, 8'hAA);
    send_item(FUNC_TARGET, 8'h55);
    send_item(FUNC_TARGET, 8'hAA);
    send_item(FUNC_TEXT, 8'h55);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hAA);
    send_item(FUNC_TEXT, 8'h55);
    send_item(FUNC_TARGET, 8'h00);
    send_item(FUNC_TARGET, 8'h55);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h55);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TEXT, 8'hAA);
    send_item(FUNC_UNUSED, 8'h55);
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_TARGET, 8'hFF);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_UNUSED, 8'h00);
  endtask

  // Long window: covering bytes at both ends of a long text run, then a late target.
  task automatic test_long_window();
    send_item(FUNC_CLEAR, 8'h00);
    send_item(FUNC_TARGET, 8'h00);
    send_item(FUNC_TARGET, 8'hFF);
    send_item(FUNC_TEXT, 8'h00);
    repeat (LONG_SPAN - 2) send_item(FUNC_TEXT, SYM_W'($urandom_range(1, 254)));
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TEXT, 8'h00);
    send_item(FUNC_TARGET, 8'h12);
  endtask

  // Text with no target, then a target that only the last byte satisfies.
  task automatic test_late_target();
    send_item(FUNC_CLEAR, 8'h00);
    repeat (LATE_SPAN - 1) send_item(FUNC_TEXT, SYM_W'($urandom_range(0, 254)));
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_TARGET, 8'hFF);
    send_item(FUNC_TEXT, 8'hFF);
    send_item(FUNC_CLEAR, 8'h00);
  endtask

  task automatic test_target_repeats();
    send_item(FUNC_CLEAR, 8'h00);
    repeat (8) send_item(FUNC_TARGET, 8'h5A);
    send_item(FUNC_TARGET, 8'hA5);
    repeat (4) send_item(FUNC_TEXT, 8'h5A);
    send_item(FUNC_TEXT, 8'hA5);
    repeat (4) send_item(FUNC_TEXT, 8'h5A);
    send_item(FUNC_TEXT, 8'hA5);
    send_item(FUNC_CLEAR, 8'h00);
  endtask

  task automatic test_random_sequences(input int n_items);
    logic [SYM_W-1:0] alpha [4];
    int               sent;
    int               n_alpha;
    int               roll;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(FUNC_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        n_alpha = $urandom_range(1, 4);
        foreach (alpha[i]) alpha[i] = SYM_W'($urandom_range(0, 255));
        send_item(FUNC_CLEAR, SYM_W'($urandom_range(0, 255)));
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send_item(FUNC_TARGET, alpha[$urandom_range(0, n_alpha - 1)]);
          sent++;
        end
        repeat ($urandom_range(8, 48)) begin
          roll = $urandom_range(0, 29);
          if (roll == 0)
            send_item(FUNC_TARGET, alpha[$urandom_range(0, n_alpha - 1)]);
          else if (roll == 1)
            send_item(FUNC_UNUSED, SYM_W'($urandom_range(0, 255)));
          else if (roll < 6)
            send_item(FUNC_TEXT, SYM_W'($urandom_range(0, 255)));
          else
            send_item(FUNC_TEXT, alpha[$urandom_range(0, n_alpha - 1)]);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.func   = FUNC_CLEAR;
    in_chan.symbol = '0;
    foreach (text_mem[i]) text_mem[i] = '0;
    clear_cover_state();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 14;
    rx_idle_pct = 54;
    test_basics();
    test_long_window();
    test_random_sequences(RANDOM_ITEMS);

    tx_idle_pct = 54;
    rx_idle_pct = 14;
    test_late_target();
    test_target_repeats();
    test_random_sequences(RANDOM_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_sequences(RANDOM_ITEMS);

    in_chan.valid <= 1'b0;
    while (expected_covers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
